// ----- rtl/bfm_pkg.sv -----
// bfm_pkg: shared types, constants and the divisor table of the 3x3 box mean filter
// depends on nothing; imported by every module of the filter

package bfm_pkg;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int SUM_W      = 12;
  localparam int CSUM_W     = 10;
  localparam int CNT_W      = 4;
  localparam int RECIP_W    = 17;
  localparam int RECIP_SH   = 16;
  localparam int PROD_W     = SUM_W + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] px;
  } bfm_item_t;

  typedef enum logic [1:0] {
    ST_READ,
    ST_SHIFT,
    ST_SUM,
    ST_DIV
  } bfm_state_t;

  // ceil(2^16 / count), exact floor for sums up to 9 * 255
  function automatic logic [RECIP_W-1:0] recip_f(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    unique case (cnt)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10923;
      4'd9:    m = 17'd7282;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/bfm_front.sv -----
// bfm_front: input side of the box filter, takes transfers and queues pixels
// flush items become zero pixels; two-entry queue toward bfm_back; uses bfm_pkg

module bfm_front
  import bfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_req_type,
  input  logic [PIX_W-1:0] in_pixel_in,
  input  logic             q_pop,
  output bfm_item_t        q_item
);

  logic [PIX_W-1:0] buf_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;
  logic             push;
  logic             pop;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (count_r != 2'd0);

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= (in_req_type == REQ_FLUSH) ? '0 : in_pixel_in;
    end
  end

  assign q_item.valid = (count_r != 2'd0);
  assign q_item.px    = buf_r[rd_ptr_r];

endmodule

// ----- rtl/bfm_back.sv -----
// bfm_back: row stores, 3x3 window, border-aware mean and output register
// sequences one queued pixel at a time; uses bfm_pkg

module bfm_back
  import bfm_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bfm_item_t                             q_item,
  output logic                                  q_pop,
  input  logic [$clog2(MAX_WIDTH+2)-1:0]        w_eff,
  input  logic [FH_W-1:0]                       h_eff,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [PIX_W-1:0]                      out_smoothed_pixel,
  output logic                                  out_last_of_frame
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 2);

  bfm_state_t state_r;
  bfm_state_t state_nxt;

  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];

  logic [AW-1:0]     in_col_r;
  logic [AW-1:0]     out_col_r;
  logic [FH_W-1:0]   out_row_r;
  logic [WW-1:0]     lag_r;
  logic [PIX_W-1:0]  win_r [9];
  logic [PIX_W-1:0]  top_r;
  logic [PIX_W-1:0]  mid_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              last_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_last_r;

  logic [AW-1:0]     in_col_c;
  logic [AW-1:0]     out_col_c;
  logic [FH_W-1:0]   out_row_c;
  logic [WW-1:0]     in_col_inc;
  logic [WW-1:0]     out_col_inc;
  logic [FH_W:0]     out_row_inc;
  logic              lagging;
  logic              has_l, has_r, has_t, has_b;
  logic [CSUM_W-1:0] csum [3];
  logic [SUM_W-1:0]  sum_c;
  logic [1:0]        ncol, nrow;
  logic [CNT_W-1:0]  cnt_c;
  logic              last_c;
  logic [PROD_W-1:0] prod;
  logic              out_free;
  logic              rd_en;
  logic              shift_en;
  logic              sum_en;
  logic              load_en;

  // counters that sit past a shrunken frame restart at zero
  assign in_col_c  = (WW'(in_col_r) >= w_eff) ? '0 : in_col_r;
  assign out_col_c = (WW'(out_col_r) >= w_eff) ? '0 : out_col_r;
  assign out_row_c = (out_row_r >= h_eff) ? '0 : out_row_r;

  assign in_col_inc  = WW'(in_col_r) + WW'(1);
  assign out_col_inc = WW'(out_col_r) + WW'(1);
  assign out_row_inc = (FH_W+1)'(out_row_r) + (FH_W+1)'(1);
  assign lagging     = lag_r < (w_eff + WW'(1));

  // border masks of the output position
  assign has_l = (out_col_r != '0);
  assign has_r = out_col_inc < w_eff;
  assign has_t = (out_row_r != '0);
  assign has_b = out_row_inc < (FH_W+1)'(h_eff);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      csum[c] = (has_t ? CSUM_W'(win_r[c*3]) : '0) + CSUM_W'(win_r[c*3+1])
              + (has_b ? CSUM_W'(win_r[c*3+2]) : '0);
    end
  end

  assign sum_c  = (has_l ? SUM_W'(csum[0]) : '0) + SUM_W'(csum[1])
                + (has_r ? SUM_W'(csum[2]) : '0);
  assign ncol   = 2'd1 + {1'b0, has_l} + {1'b0, has_r};
  assign nrow   = 2'd1 + {1'b0, has_t} + {1'b0, has_b};
  assign cnt_c  = CNT_W'(ncol) * CNT_W'(nrow);
  assign last_c = (out_row_r == (h_eff - FH_W'(1))) && (WW'(out_col_r) == (w_eff - WW'(1)));

  assign prod     = PROD_W'(sum_r) * PROD_W'(recip_f(cnt_r));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_READ:  if (q_item.valid) state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = lagging ? ST_READ : ST_SUM;
      ST_SUM:   state_nxt = ST_DIV;
      ST_DIV:   if (out_free) state_nxt = ST_READ;
      default:  state_nxt = ST_READ;
    endcase
  end

  always_comb begin
    rd_en    = 1'b0;
    shift_en = 1'b0;
    sum_en   = 1'b0;
    load_en  = 1'b0;
    q_pop    = 1'b0;
    unique case (state_r)
      ST_READ:  rd_en = q_item.valid;
      ST_SHIFT: begin
        shift_en = 1'b1;
        q_pop    = lagging;
      end
      ST_SUM:   sum_en = 1'b1;
      ST_DIV:   begin
        load_en = out_free;
        q_pop   = out_free;
      end
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READ;
      in_col_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      lag_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (rd_en) begin
        in_col_r  <= in_col_c;
        out_col_r <= out_col_c;
        out_row_r <= out_row_c;
      end
      if (shift_en) begin
        for (int i = 0; i < 6; i++) win_r[i] <= win_r[i+3];
        win_r[6] <= top_r;
        win_r[7] <= mid_r;
        win_r[8] <= q_item.px;
        in_col_r <= (in_col_inc >= w_eff) ? '0 : AW'(in_col_inc);
        if (lagging) lag_r <= lag_r + WW'(1);
      end
      if (load_en) begin
        if (last_r) begin
          in_col_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
          lag_r     <= '0;
        end else if (out_col_inc >= w_eff) begin
          out_col_r <= '0;
          out_row_r <= (out_row_inc >= (FH_W+1)'(h_eff)) ? '0 : out_row_inc[FH_W-1:0];
        end else begin
          out_col_r <= AW'(out_col_inc);
        end
      end
      if (load_en) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // row stores: read one column above the new pixel, then push it down
  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_r <= older_mem[in_col_c];
      mid_r <= newer_mem[in_col_c];
    end
    if (shift_en) begin
      older_mem[in_col_r] <= mid_r;
      newer_mem[in_col_r] <= q_item.px;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      sum_r  <= sum_c;
      cnt_r  <= cnt_c;
      last_r <= last_c;
    end
    if (load_en) begin
      out_pix_r  <= prod[RECIP_SH +: PIX_W];
      out_last_r <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_pixel = out_pix_r;
  assign out_last_of_frame  = out_last_r;

endmodule

// ----- rtl/box_filter_3x3_edge_mean.sv -----
// box_filter_3x3_edge_mean: top level, frame registers, bfm_front and bfm_back
// sequence: an item is queued, then the back sequencer reads and shifts it and, for an item that
// gives a result, sums and divides before the output register loads; it holds one item at a time,
// the divide step waits for a free output register, and the two-entry queue takes new items meanwhile
// reset: queue, counters, window and output cleared; width and height go to 1; row stores keep data

module box_filter_3x3_edge_mean
  import bfm_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [PIX_W-1:0]      in_pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_smoothed_pixel,
  output logic                  out_last_of_frame,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WW = $clog2(MAX_WIDTH + 2);

  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic [31:0]     fw_ext;
  logic [31:0]     w_clamp;
  logic [WW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;
  bfm_item_t       q_item;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_W'(1);
      frame_height_r <= FH_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FH_W-1:0];
        default:          ;
      endcase
    end
  end

  assign fw_ext  = 32'(frame_width_r);
  assign w_clamp = (fw_ext == 32'd0) ? 32'd1 :
                   (fw_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : fw_ext;
  assign w_eff   = w_clamp[WW-1:0];
  assign h_eff   = (frame_height_r == '0) ? FH_W'(1) : frame_height_r;

  bfm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_pixel_in (in_pixel_in),
    .q_pop       (q_pop),
    .q_item      (q_item)
  );

  bfm_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .w_eff              (w_eff),
    .h_eff              (h_eff),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_smoothed_pixel (out_smoothed_pixel),
    .out_last_of_frame  (out_last_of_frame)
  );

  // the back part only consumes items that the queue holds
  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_item.valid)
    else $error("pop from empty queue");

  // reset leaves the queue empty and open
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // a new result is always tied to retiring a queued item
  a_result_retires: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop))
    else $error("result without retired item");

endmodule
